@@ src/ps2mct_pkg.sv @@
package ps2mct_pkg;

	// Byte phase codes
	localparam logic [1:0] PHASE_HEADER = 2'd0;
	localparam logic [1:0] PHASE_X      = 2'd1;
	localparam logic [1:0] PHASE_Y      = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

	localparam int SIZE_W = 13;
	localparam int POS_W  = 12;
	localparam int BYTE_W = 8;

	localparam int CURSOR_MARGIN = 17;
	localparam int MOVE_DIVISOR  = 10;

	// Header byte bits
	localparam logic [BYTE_W-1:0] HDR_ACK = 8'hFA;
	localparam int HDR_LEFT_BIT   = 0;
	localparam int HDR_RIGHT_BIT  = 1;
	localparam int HDR_MIDDLE_BIT = 2;
	localparam int HDR_ONE_BIT    = 3;
	localparam int HDR_XSIGN_BIT  = 4;
	localparam int HDR_YSIGN_BIT  = 5;
	localparam int HDR_XOVF_BIT   = 6;
	localparam int HDR_YOVF_BIT   = 7;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1024;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd768;
	localparam logic [POS_W-1:0]  POS_X_RESET  = 12'd512;
	localparam logic [POS_W-1:0]  POS_Y_RESET  = 12'd384;

	// Reciprocal for the constant divide; exact for magnitudes up to 256
	localparam int RECIP_SHIFT = 17;
	localparam int RECIP       = (2**RECIP_SHIFT + MOVE_DIVISOR - 1) / MOVE_DIVISOR;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int MAG_W       = 9;
	localparam int MOVE_W      = MAG_W + 1;
	localparam int SUM_W       = POS_W + 2;

	typedef logic signed [MOVE_W-1:0] move_t;

	// Sign-extend a movement byte to nine bits and divide, truncating toward zero
	function automatic move_t move_div(input logic [BYTE_W-1:0] b, input logic neg);
		logic [MAG_W-1:0]         mag;
		logic [RECIP_W+MAG_W-1:0] prod;
		logic [MAG_W-1:0]         q;
		move_t                    sq;
		mag  = neg ? MAG_W'(9'd256 - {1'b0, b}) : {1'b0, b};
		prod = (RECIP_W + MAG_W)'(mag) * (RECIP_W + MAG_W)'(RECIP);
		q    = prod[RECIP_SHIFT +: MAG_W];
		sq   = $signed({1'b0, q});
		return neg ? -sq : sq;
	endfunction

	// Screen size minus margin, saturated to the position range
	function automatic logic [POS_W-1:0] axis_limit(input logic [SIZE_W-1:0] size);
		logic signed [SUM_W-1:0] diff;
		diff = $signed({1'b0, size}) - SUM_W'(CURSOR_MARGIN);
		if (diff < 0)
			return '0;
		else if (diff > $signed(SUM_W'(2**POS_W - 1)))
			return '1;
		else
			return diff[POS_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] clamp_pos(input logic signed [SUM_W-1:0] v,
		input logic [POS_W-1:0] lim);
		if (v < 0)
			return '0;
		else if (v > $signed({2'b00, lim}))
			return lim;
		else
			return v[POS_W-1:0];
	endfunction

endpackage

@@ src/ps2_mouse_cursor_tracker.sv @@
// PS/2 mouse cursor tracker.
// Input channel (in_valid / in_stall / rx_byte): one byte of the mouse stream
// per request. Bytes are grouped as header, X movement, Y movement; a header
// that is an ACK, lacks its always-one bit or flags an overflow is dropped.
// Output channel (out_valid / out_stall): one request per complete packet with
// the clamped cursor position and the left, right and middle button bits.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): screen width
// at index 0, screen height at index 1; cfg_ready is always high.
// A Y byte passes from the input register to the result register, where its
// result shows. Throughput: one byte per cycle while no Y byte waits on a held
// result, set by the single pass from the input register to the result register.
// Reset clears the packet phase, puts the cursor at 512/384 and the screen at
// 1024x768. While out_stall holds a result, header and X bytes keep flowing;
// a Y byte waits in the input register and in_stall rises until the result
// register is taken.
module ps2_mouse_cursor_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ps2mct_pkg::BYTE_W-1:0]       rx_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ps2mct_pkg::POS_W-1:0]        cursor_x,
	output logic [ps2mct_pkg::POS_W-1:0]        cursor_y,
	output logic                                left_button,
	output logic                                right_button,
	output logic                                middle_button,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ps2mct_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ps2mct_pkg::SIZE_W-1:0]       cfg_data
);
	import ps2mct_pkg::*;

	// Input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Packet and cursor state
	logic [1:0]        phase_q;
	logic [BYTE_W-1:0] header_q;
	logic [BYTE_W-1:0] xbyte_q;
	logic [POS_W-1:0]  pos_x_q;
	logic [POS_W-1:0]  pos_y_q;
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;

	// Result register
	logic              out_valid_q;
	logic [POS_W-1:0]  cursor_x_q;
	logic [POS_W-1:0]  cursor_y_q;
	logic [2:0]        buttons_q;

	logic              advance;
	logic              accept;
	logic              emit;
	logic              header_ok;
	move_t             dx;
	move_t             dy;
	logic [SUM_W-1:0]  sum_x;
	logic [SUM_W-1:0]  sum_y;
	logic [POS_W-1:0]  next_x;
	logic [POS_W-1:0]  next_y;

	assign cfg_ready = 1'b1;

	// A Y byte needs the result register free or draining this cycle
	assign emit     = valid_s1 && (phase_q == PHASE_Y);
	assign advance  = valid_s1 && (!emit || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign header_ok = (byte_s1 != HDR_ACK) && byte_s1[HDR_ONE_BIT]
		&& !byte_s1[HDR_XOVF_BIT] && !byte_s1[HDR_YOVF_BIT];

	// Movement, divide, move and clamp in one pass
	always_comb begin
		dx     = move_div(xbyte_q, header_q[HDR_XSIGN_BIT]);
		dy     = move_div(byte_s1, header_q[HDR_YSIGN_BIT]);
		sum_x  = SUM_W'($signed({2'b00, pos_x_q}) + SUM_W'(dx));
		sum_y  = SUM_W'($signed({2'b00, pos_y_q}) - SUM_W'(dy));
		next_x = clamp_pos($signed(sum_x), axis_limit(width_q));
		next_y = clamp_pos($signed(sum_y), axis_limit(height_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

	// Configuration writes; indexes beyond the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Packet sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PHASE_HEADER;
			header_q <= '0;
			xbyte_q  <= '0;
			pos_x_q  <= POS_X_RESET;
			pos_y_q  <= POS_Y_RESET;
		end else if (advance) begin
			case (phase_q)
				PHASE_X: begin
					xbyte_q <= byte_s1;
					phase_q <= PHASE_Y;
				end
				PHASE_Y: begin
					pos_x_q <= next_x;
					pos_y_q <= next_y;
					phase_q <= PHASE_HEADER;
				end
				default: begin
					// header phase; drop a bad header and keep waiting
					if (header_ok) begin
						header_q <= byte_s1;
						phase_q  <= PHASE_X;
					end else begin
						phase_q  <= PHASE_HEADER;
					end
				end
			endcase
		end
	end

	// Result register: load on a Y byte, clear once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			cursor_x_q <= next_x;
			cursor_y_q <= next_y;
			buttons_q  <= {header_q[HDR_MIDDLE_BIT], header_q[HDR_RIGHT_BIT],
				header_q[HDR_LEFT_BIT]};
		end
	end

	assign out_valid     = out_valid_q;
	assign cursor_x      = cursor_x_q;
	assign cursor_y      = cursor_y_q;
	assign left_button   = buttons_q[0];
	assign right_button  = buttons_q[1];
	assign middle_button = buttons_q[2];

endmodule

@@ src/ps2mct_checker.sv @@
module ps2mct_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [ps2mct_pkg::POS_W-1:0]        cursor_x,
	input logic [ps2mct_pkg::POS_W-1:0]        cursor_y,
	input logic                                left_button,
	input logic                                right_button,
	input logic                                middle_button
);
	import ps2mct_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(cursor_x) && $stable(cursor_y)
			&& $stable(left_button) && $stable(right_button) && $stable(middle_button))
		else $error("stalled result changed");

	// Backpressure on input only while the result register is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// A fresh result follows a byte accepted into the input register and then passed to the result register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a recent input byte");

endmodule

bind ps2_mouse_cursor_tracker ps2mct_checker u_ps2mct_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.cursor_x      (cursor_x),
	.cursor_y      (cursor_y),
	.left_button   (left_button),
	.right_button  (right_button),
	.middle_button (middle_button)
);
